@@ hdl/ips_pkg.sv @@
// Shared constants and types for the incremental PID step block.
package ips_pkg;

	localparam int GAIN_WIDTH          = 16;
	localparam int SAMPLE_WIDTH_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF  = 12;
	localparam int CFG_INDEX_WIDTH     = 3;
	localparam int MID_DEPTH           = 4;
	localparam int OUT_DEPTH           = 4;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_CLAMP_ENABLE = 3'd3,
		REG_BOUND_LOW    = 3'd4,
		REG_BOUND_HIGH   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_WIDTH-1:0] kp;
		logic signed [GAIN_WIDTH-1:0] ki;
		logic signed [GAIN_WIDTH-1:0] kd;
	} gains_t;

endpackage

@@ hdl/ips_fifo.sv @@
// Small register-based first-in first-out queue with occupancy count.
module ips_fifo import ips_pkg::*; #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       full,
	output logic                       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ hdl/ips_front.sv @@
// Front end: forms the error, keeps the error history and the difference terms.
module ips_front import ips_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic signed [SAMPLE_WIDTH-1:0] measured,
	input  logic signed [SAMPLE_WIDTH-1:0] target,
	output logic signed [SAMPLE_WIDTH+1:0] diff1,
	output logic signed [SAMPLE_WIDTH+1:0] sum1,
	output logic signed [SAMPLE_WIDTH+2:0] diff2
);

	localparam int SW = SAMPLE_WIDTH;

	logic signed [SW:0] err;
	logic signed [SW:0] e1_q;
	logic signed [SW:0] e2_q;

	assign err   = (SW+1)'(target) - (SW+1)'(measured);
	assign diff1 = (SW+2)'(err) - (SW+2)'(e1_q);
	assign sum1  = (SW+2)'(err) + (SW+2)'(e1_q);
	assign diff2 = (SW+3)'(err) - ((SW+3)'(e1_q) <<< 1) + (SW+3)'(e2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
		end else if (accept) begin
			e2_q <= e1_q;
			e1_q <= err;
		end
	end

endmodule

@@ hdl/ips_back.sv @@
// Back end: gain multiplies, rounding, saturation and clamping over two stages.
module ips_back import ips_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gains_t                           gains,
	input  logic                             clamp_en,
	input  logic signed [SAMPLE_WIDTH-1:0]   bound_low,
	input  logic signed [SAMPLE_WIDTH-1:0]   bound_high,
	input  logic                             word_valid,
	input  logic signed [SAMPLE_WIDTH-1:0]   word_meas,
	input  logic signed [SAMPLE_WIDTH+1:0]   word_diff1,
	input  logic signed [SAMPLE_WIDTH+1:0]   word_sum1,
	input  logic signed [SAMPLE_WIDTH+2:0]   word_diff2,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
	output logic                             word_take,
	output logic                             res_valid,
	output logic signed [SAMPLE_WIDTH-1:0]   res_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int GW = GAIN_WIDTH;
	localparam int F  = GAIN_FRAC_BITS;
	localparam int AW = GW + SW + 4;
	localparam int CW = $clog2(OUT_DEPTH+1);

	localparam logic signed [AW:0] RMAX = {{(AW-SW+2){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [AW:0] RMIN = {{(AW-SW+2){1'b1}}, {(SW-1){1'b0}}};

	logic signed [GW+SW+1:0] p_prop;
	logic signed [GW+SW+1:0] p_integ;
	logic signed [GW+SW+2:0] p_deriv;

	logic                    v_s1;
	logic signed [GW+SW+1:0] p_prop_s1;
	logic signed [GW+SW+1:0] p_integ_s1;
	logic signed [GW+SW+2:0] p_deriv_s1;
	logic signed [SW-1:0]    meas_s1;

	logic signed [AW-1:0]    acc;
	logic signed [AW-1:0]    corr;
	logic signed [AW:0]      sum;
	logic signed [SW-1:0]    sat;
	logic signed [SW-1:0]    clamped;

	logic                    v_s2;
	logic signed [SW-1:0]    res_s2;

	// credit against the output queue covers words still in flight
	assign word_take = word_valid &&
		((CW+1)'(out_count) + (CW+1)'(v_s1) + (CW+1)'(v_s2) < (CW+1)'(OUT_DEPTH));

	assign p_prop  = $signed(gains.kp) * word_diff1;
	assign p_integ = $signed(gains.ki) * word_sum1;
	assign p_deriv = $signed(gains.kd) * word_diff2;

	// round half up: add half an LSB of the result, then floor
	assign acc = (AW'(p_prop_s1) <<< 1) + AW'(p_integ_s1) + (AW'(p_deriv_s1) <<< 1)
		+ (AW'(1) <<< F);
	assign corr = acc >>> (F + 1);
	assign sum  = (AW+1)'(meas_s1) + (AW+1)'(corr);

	always_comb begin
		if (sum < RMIN) begin
			sat = RMIN[SW-1:0];
		end else if (sum > RMAX) begin
			sat = RMAX[SW-1:0];
		end else begin
			sat = sum[SW-1:0];
		end
		clamped = sat;
		if (clamp_en) begin
			if (clamped < bound_low) begin
				clamped = bound_low;
			end
			if (clamped > bound_high) begin
				clamped = bound_high;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= word_take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (word_take) begin
			p_prop_s1  <= p_prop;
			p_integ_s1 <= p_integ;
			p_deriv_s1 <= p_deriv;
			meas_s1    <= word_meas;
		end
		if (v_s1) begin
			res_s2 <= clamped;
		end
	end

	assign res_valid = v_s2;
	assign res_data  = res_s2;

endmodule

@@ hdl/incremental_pid_step.sv @@
// Top level of the incremental (velocity-form) PID step block.
// Takes one measured/target word per clock while full is low and returns one setpoint
// word per word taken, in order. A pushed word is written to the error queue; the
// first stage then registers the three gain multiplies fed straight from the error
// queue, the second the rounding sum, saturation and clamp, and the result queue is
// written after that. Throughput is one word per clock while the reader keeps popping;
// the two-stage arithmetic pipeline runs against a four-entry result queue, and
// full rises only when the error queue backs up behind a stalled reader.
// Configuration writes are always ready and also reach words already queued.
module incremental_pid_step import ips_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [SAMPLE_WIDTH-1:0] measured,
	input  logic signed [SAMPLE_WIDTH-1:0] target,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [SAMPLE_WIDTH-1:0] setpoint,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [((SAMPLE_WIDTH > GAIN_WIDTH) ? SAMPLE_WIDTH : GAIN_WIDTH)-1:0] cfg_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int MW = 4 * SW + 7;

	gains_t               gains_q;
	logic                 clamp_en_q;
	logic signed [SW-1:0] bound_low_q;
	logic signed [SW-1:0] bound_high_q;

	logic                 accept;
	logic signed [SW+1:0] diff1;
	logic signed [SW+1:0] sum1;
	logic signed [SW+2:0] diff2;

	logic [MW-1:0]        mid_wr;
	logic [MW-1:0]        mid_rd;
	logic                 mid_empty;
	logic                 mid_take;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

	logic                 res_valid;
	logic signed [SW-1:0] res_data;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	logic                 out_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q      <= '0;
			clamp_en_q   <= 1'b0;
			bound_low_q  <= {1'b1, {(SW-1){1'b0}}};
			bound_high_q <= {1'b0, {(SW-1){1'b1}}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:    gains_q.kp   <= cfg_data[GAIN_WIDTH-1:0];
				REG_INTEG_GAIN:   gains_q.ki   <= cfg_data[GAIN_WIDTH-1:0];
				REG_DERIV_GAIN:   gains_q.kd   <= cfg_data[GAIN_WIDTH-1:0];
				REG_CLAMP_ENABLE: clamp_en_q   <= cfg_data[0];
				REG_BOUND_LOW:    bound_low_q  <= cfg_data[SW-1:0];
				REG_BOUND_HIGH:   bound_high_q <= cfg_data[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign accept = push && !full;

	ips_front #(
		.SAMPLE_WIDTH(SW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.measured (measured),
		.target   (target),
		.diff1    (diff1),
		.sum1     (sum1),
		.diff2    (diff2)
	);

	assign mid_wr = {measured, diff1, sum1, diff2};

	ips_fifo #(
		.WIDTH(MW),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (mid_wr),
		.rd_en   (mid_take),
		.rd_data (mid_rd),
		.count   (mid_count),
		.full    (full),
		.empty   (mid_empty)
	);

	ips_back #(
		.SAMPLE_WIDTH   (SW),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gains      (gains_q),
		.clamp_en   (clamp_en_q),
		.bound_low  (bound_low_q),
		.bound_high (bound_high_q),
		.word_valid (!mid_empty && (mid_count != '0)),
		.word_meas  (mid_rd[MW-1 -: SW]),
		.word_diff1 (mid_rd[3*SW+6 -: SW+2]),
		.word_sum1  (mid_rd[2*SW+4 -: SW+2]),
		.word_diff2 (mid_rd[SW+2:0]),
		.out_count  (out_count),
		.word_take  (mid_take),
		.res_valid  (res_valid),
		.res_data   (res_data)
	);

	ips_fifo #(
		.WIDTH(SW),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res_data),
		.rd_en   (pop),
		.rd_data (setpoint),
		.count   (out_count),
		.full    (out_full),
		.empty   (empty)
	);

	logic unused_full;
	assign unused_full = out_full;

endmodule

@@ tb/tb_incremental_pid_step.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for incremental_pid_step: directed and random words against a predictor.
module tb_incremental_pid_step;
	import ips_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int FRAC = GAIN_FRAC_BITS_DEF;
	localparam int CFG_DW = (SW > GAIN_WIDTH) ? SW : GAIN_WIDTH;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [GAIN_WIDTH-1:0] G_MIN = {1'b1, {(GAIN_WIDTH-1){1'b0}}};
	localparam logic signed [GAIN_WIDTH-1:0] G_MAX = {1'b0, {(GAIN_WIDTH-1){1'b1}}};
	localparam int CYCLE_LIMIT = 300000;
	localparam int RAND_SEGMENTS = 14;
	localparam int SEGMENT_WORDS = 50;

	class setpoint_scoreboard;
		logic signed [GAIN_WIDTH-1:0] kp, ki, kd;
		bit clamp_on;
		logic signed [SW-1:0] lo_bound, hi_bound;
		logic signed [SW:0] err_d1, err_d2;
		logic signed [SW-1:0] due_setpoints[$];
		int errors;

		function new();
			kp = '0;
			ki = '0;
			kd = '0;
			clamp_on = 1'b0;
			lo_bound = S_MIN;
			hi_bound = S_MAX;
			err_d1 = '0;
			err_d2 = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
				REG_PROP_GAIN: kp = data[GAIN_WIDTH-1:0];
				REG_INTEG_GAIN: ki = data[GAIN_WIDTH-1:0];
				REG_DERIV_GAIN: kd = data[GAIN_WIDTH-1:0];
				REG_CLAMP_ENABLE: clamp_on = data[0];
				REG_BOUND_LOW: lo_bound = data[SW-1:0];
				REG_BOUND_HIGH: hi_bound = data[SW-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [SW-1:0] pid_setpoint(logic signed [SW-1:0] m,
				logic signed [SW-1:0] t);
			longint e, d1, s1, d2, acc, r;
			e = longint'(t) - longint'(m);
			d1 = e - err_d1;
			s1 = e + err_d1;
			d2 = e - 2 * longint'(err_d1) + err_d2;
			acc = 2 * longint'(kp) * d1 + longint'(ki) * s1 + 2 * longint'(kd) * d2;
			// round half up, then saturate and clamp
			r = longint'(m) + ((acc + (longint'(1) <<< FRAC)) >>> (FRAC + 1));
			if (r < S_MIN) r = S_MIN;
			if (r > S_MAX) r = S_MAX;
			if (clamp_on) begin
				if (r < lo_bound) r = lo_bound;
				if (r > hi_bound) r = hi_bound;
			end
			err_d2 = err_d1;
			err_d1 = e[SW:0];
			return r[SW-1:0];
		endfunction

		function void take_word(logic signed [SW-1:0] m, logic signed [SW-1:0] t);
			due_setpoints.push_back(pid_setpoint(m, t));
		endfunction

		task report(string msg);
			if (errors < 100) $display("%0t: %s", $time, msg);
			errors++;
		endtask

		task check_setpoint(logic signed [SW-1:0] got);
			logic signed [SW-1:0] want;
			if (due_setpoints.size() == 0) begin
				report($sformatf("setpoint %0d with no word outstanding", got));
				return;
			end
			want = due_setpoints.pop_front();
			if (got !== want) report($sformatf("setpoint %0d, want %0d", got, want));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [SW-1:0] measured = '0;
	logic signed [SW-1:0] target = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [SW-1:0] setpoint;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;
	setpoint_scoreboard sb = new();

	incremental_pid_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.measured(measured),
		.target(target),
		.empty(empty),
		.pop(pop),
		.setpoint(setpoint),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("incremental_pid_step: mismatch");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) sb.check_setpoint(setpoint);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			2, 3: return SW'(int'($urandom_range(2047)) - 1024);
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic signed [GAIN_WIDTH-1:0] rand_gain();
		case ($urandom_range(7))
			0: return G_MIN;
			1: return G_MAX;
			2: return '0;
			3, 4, 5: return GAIN_WIDTH'(int'($urandom_range(16383)) - 8192);
			default: return GAIN_WIDTH'($urandom);
		endcase
	endfunction

	task automatic send_word(input logic signed [SW-1:0] m, input logic signed [SW-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		measured <= m;
		target <= t;
		do @(posedge clk); while (full);
		sb.take_word(m, t);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic load_settings(input logic signed [GAIN_WIDTH-1:0] kp,
			input logic signed [GAIN_WIDTH-1:0] ki, input logic signed [GAIN_WIDTH-1:0] kd,
			input logic [CFG_DW-1:0] clamp_word, input logic signed [SW-1:0] lo,
			input logic signed [SW-1:0] hi, input bit spare);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_CLAMP_ENABLE, clamp_word);
		write_reg(REG_BOUND_LOW, lo);
		write_reg(REG_BOUND_HIGH, hi);
		if (spare) begin
			write_reg(CFG_SPARE_LO, CFG_DW'($urandom));
			write_reg(CFG_SPARE_HI, CFG_DW'($urandom));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender holds off until every outstanding word has come back
	task automatic settle();
		push <= 1'b0;
		while (sb.due_setpoints.size() != 0) @(posedge clk);
	endtask

	task automatic random_segment(input int n);
		logic signed [SW-1:0] m, t;
		longint near;
		for (int i = 0; i < n; i++) begin
			m = rand_sample();
			if ($urandom_range(1)) begin
				near = longint'(m) + int'($urandom_range(400)) - 200;
				if (near < S_MIN) near = S_MIN;
				if (near > S_MAX) near = S_MAX;
				t = near[SW-1:0];
			end else begin
				t = rand_sample();
			end
			send_word(m, t);
		end
		settle();
	endtask

	initial begin
		logic signed [SW-1:0] lo, hi, swap;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: setpoint follows measured
		send_word('0, '0);
		send_word(S_MIN, S_MAX);
		send_word(S_MAX, S_MIN);
		send_word(S_MAX, S_MAX);
		send_word(S_MIN, S_MIN);
		settle();

		// largest gains, saturation both ways, bounds ignored with clamp off
		load_settings(G_MAX, G_MAX, G_MAX, '0, 16'sd100, -16'sd100, 1'b0);
		send_word(S_MIN, S_MAX);
		send_word(S_MAX, S_MIN);
		send_word('0, '0);
		send_word('0, 16'sd1);
		send_word(16'sd1, '0);
		settle();

		load_settings(G_MIN, G_MIN, G_MIN, 16'h0001, S_MIN, S_MAX, 1'b0);
		send_word(S_MAX, S_MIN);
		send_word(S_MIN, S_MAX);
		send_word(-16'sd1, '0);
		send_word('0, -16'sd1);
		settle();

		// narrow window; clamp word carries junk high bits, spare indexes written
		load_settings(16'sd4096, 16'sd2048, '0, {CFG_DW{1'b1}}, -16'sd100, 16'sd100, 1'b1);
		send_word('0, 16'sd500);
		send_word('0, -16'sd500);
		send_word(16'sd50, 16'sd60);
		send_word(S_MAX, S_MAX);
		settle();

		// inverted bounds give bound_high
		load_settings(16'sd4096, '0, 16'sd1024, 16'h0003, 16'sd500, -16'sd500, 1'b0);
		send_word('0, '0);
		send_word(16'sd1000, -16'sd1000);
		send_word(-16'sd1000, 16'sd1000);
		settle();

		// exact halves either side of zero round upward
		load_settings('0, 16'sd1, '0, 16'hFFFE, S_MIN, S_MAX, 1'b0);
		send_word('0, 16'sd2096);
		send_word(16'sd6192, '0);
		settle();

		for (int s = 0; s < RAND_SEGMENTS; s++) begin
			if (s < 5) begin
				send_idle_pct = 33;
				recv_idle_pct = 83;
			end else if (s < 10) begin
				send_idle_pct = 83;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			lo = rand_sample();
			hi = rand_sample();
			if ($urandom_range(4) != 0 && lo > hi) begin
				swap = lo;
				lo = hi;
				hi = swap;
			end
			load_settings(rand_gain(), rand_gain(), rand_gain(), CFG_DW'($urandom), lo, hi,
				$urandom_range(3) == 0);
			random_segment(SEGMENT_WORDS);
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("incremental_pid_step: match");
		end else begin
			$display("incremental_pid_step: mismatch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/ips_pkg.sv
hdl/ips_fifo.sv
hdl/ips_front.sv
hdl/ips_back.sv
hdl/incremental_pid_step.sv
tb/tb_incremental_pid_step.sv
